// ===== src/packetizing_ring_buffer_defines.svh =====
// Assertion macros shared by the packetizing ring buffer RTL.
// No dependencies; include with the bare file name where assertions are written.
`ifndef PACKETIZING_RING_BUFFER_DEFINES_SVH
`define PACKETIZING_RING_BUFFER_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define PRB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define PRB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/prb_pkg.sv =====
// Shared constants and request codes for the packetizing ring buffer.
// No dependencies; used by prb_ram instantiation and the top level.
`default_nettype none

package prb_pkg;

  localparam int BUF_DEPTH  = 32768;
  localparam int BUF_AW     = $clog2(BUF_DEPTH);
  localparam int BYTE_W     = 8;
  localparam int PACKET_MAX = 63;
  localparam int CNT_W      = $clog2(PACKET_MAX + 1);
  localparam int THR_W      = 6;
  localparam int REQ_W      = 2;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(63);

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE   = 2'd0,
    REQ_TX_DONE = 2'd1,
    REQ_CONFIG  = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

endpackage

`default_nettype wire

// ===== src/packetizing_ring_buffer.sv =====
// Packetizing byte ring buffer: top level with control, pointers and output register.
// Depends on prb_pkg, prb_ram and packetizing_ring_buffer_defines.svh.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------------
//   in      | input     | in_valid / in_ready   | in_req_type, in_write_byte, in_end_of_write
//   out     | output    | out_valid / out_ready | out_byte, out_has_data, out_last,
//           |           |                       | out_overflow_flag, out_fill_level
//   cfg     | input     | cfg_wr_en             | cfg_wr_data
//
// An item that gives a status beat is taken straight from idle; writes stream at one per cycle
// while the output register can take a beat. For a packet the item is taken, reads are issued
// from the single read port, each byte is registered by the memory and then moved into the output
// register, one beat per cycle without output stalls, and the block returns to idle after the last byte.
// No item is taken while a packet is draining. Reset needs no clearing pass.
// Output stalls are absorbed by the output register and a one-entry read holding stage.
`default_nettype none
`include "packetizing_ring_buffer_defines.svh"

module packetizing_ring_buffer (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [prb_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic [prb_pkg::BYTE_W-1:0]   in_write_byte,
  input  wire logic                         in_end_of_write,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [prb_pkg::BYTE_W-1:0]   out_byte,
  output logic                              out_has_data,
  output logic                              out_last,
  output logic                              out_overflow_flag,
  output logic      [prb_pkg::BUF_AW-1:0]   out_fill_level,
  input  wire logic                         cfg_wr_en,
  input  wire logic [prb_pkg::THR_W-1:0]    cfg_wr_data
);

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_t;

  state_t                         state_r, state_nxt;
  logic [prb_pkg::BUF_AW-1:0]     wp_r, wp_nxt;
  logic [prb_pkg::BUF_AW-1:0]     rp_r, rp_nxt;
  logic                           busy_r, busy_nxt;
  logic                           link_r, link_nxt;
  logic                           ovf_r, ovf_nxt;
  logic [prb_pkg::THR_W-1:0]      thr_r;
  logic [prb_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                           issue_done_r, issue_done_nxt;
  logic                           rd_vld_r, rd_vld_nxt;
  logic                           rd_last_r;
  logic [prb_pkg::BUF_AW-1:0]     rd_fill_r;

  logic                           out_valid_r, out_valid_nxt;
  logic [prb_pkg::BYTE_W-1:0]     out_byte_r, out_byte_nxt;
  logic                           out_data_r, out_data_nxt;
  logic                           out_last_r, out_last_nxt;
  logic                           out_ovf_r, out_ovf_nxt;
  logic [prb_pkg::BUF_AW-1:0]     out_fill_r, out_fill_nxt;

  logic                           acc, out_free, wr_go, wrap, thr_hit, send_go, empty_s;
  logic                           issue, issue_last, move, ovf_post;
  logic [prb_pkg::BUF_AW-1:0]     wp_inc, wp_w, rp_w, fill_w, wp_s, rp_s, rp_inc;
  logic [prb_pkg::BYTE_W-1:0]     rd_data;
  prb_pkg::req_t                  req;

  assign req       = prb_pkg::req_t'(in_req_type);
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign acc       = in_valid && in_ready;

  // Write path: the pointers wrap naturally since the depth is a power of two.
  assign wr_go   = acc && (req == prb_pkg::REQ_WRITE) && link_r;
  assign wp_inc  = wp_r + 1'b1;
  assign wrap    = (wp_inc == rp_r);
  assign wp_w    = wrap ? '0 : wp_inc;
  assign rp_w    = wrap ? '0 : rp_r;
  assign fill_w  = wp_w - rp_w;
  assign thr_hit = in_end_of_write && !busy_r &&
                   (fill_w >= {{(prb_pkg::BUF_AW - prb_pkg::THR_W){1'b0}}, thr_r});

  assign send_go = acc && ((req == prb_pkg::REQ_CONFIG) || (req == prb_pkg::REQ_TX_DONE) ||
                           (wr_go && thr_hit));
  assign wp_s     = wr_go ? wp_w : wp_r;
  assign rp_s     = wr_go ? rp_w : rp_r;
  assign empty_s  = (wp_s == rp_s);
  assign ovf_post = send_go ? 1'b0 : ((wr_go && wrap) ? 1'b1 : ovf_r);

  // Packet drain: one read issued per cycle while the holding stage can move on.
  assign move       = rd_vld_r && out_free;
  assign issue      = (state_r == ST_SEND) && !issue_done_r && (!rd_vld_r || move);
  assign rp_inc     = rp_r + 1'b1;
  assign issue_last = (cnt_r == prb_pkg::CNT_W'(prb_pkg::PACKET_MAX - 1)) || (rp_inc == wp_r);

  prb_ram #(
    .AW (prb_pkg::BUF_AW),
    .DW (prb_pkg::BYTE_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_go),
    .wr_addr (wp_r),
    .wr_data (in_write_byte),
    .rd_en   (issue),
    .rd_addr (rp_r),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    wp_nxt         = wp_r;
    rp_nxt         = rp_r;
    busy_nxt       = busy_r;
    link_nxt       = link_r;
    ovf_nxt        = ovf_r;
    cnt_nxt        = cnt_r;
    issue_done_nxt = issue_done_r;
    rd_vld_nxt     = issue ? 1'b1 : (move ? 1'b0 : rd_vld_r);
    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    out_ovf_nxt    = out_ovf_r;
    out_fill_nxt   = out_fill_r;

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          wp_nxt  = wp_s;
          rp_nxt  = rp_s;
          ovf_nxt = ovf_post;
          if (req == prb_pkg::REQ_CONFIG) begin
            link_nxt = 1'b1;
          end
          if (send_go) begin
            busy_nxt       = !empty_s;
            cnt_nxt        = '0;
            issue_done_nxt = 1'b0;
          end
          if (send_go && !empty_s) begin
            state_nxt = ST_SEND;
          end else begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = '0;
            out_data_nxt  = 1'b0;
            out_last_nxt  = 1'b1;
            out_ovf_nxt   = ovf_post;
            out_fill_nxt  = wp_s - rp_s;
          end
        end
      end
      ST_SEND: begin
        if (issue) begin
          rp_nxt = rp_inc;
          cnt_nxt = cnt_r + 1'b1;
          issue_done_nxt = issue_last;
        end
        if (move) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rd_data;
          out_data_nxt  = 1'b1;
          out_last_nxt  = rd_last_r;
          out_ovf_nxt   = 1'b0;
          out_fill_nxt  = rd_fill_r;
        end
        if (issue_done_r && !rd_vld_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wp_r         <= '0;
      rp_r         <= '0;
      busy_r       <= 1'b0;
      link_r       <= 1'b0;
      ovf_r        <= 1'b0;
      thr_r        <= prb_pkg::THR_RESET;
      cnt_r        <= '0;
      issue_done_r <= 1'b0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wp_r         <= wp_nxt;
      rp_r         <= rp_nxt;
      busy_r       <= busy_nxt;
      link_r       <= link_nxt;
      ovf_r        <= ovf_nxt;
      cnt_r        <= cnt_nxt;
      issue_done_r <= issue_done_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers: metadata rides along with each read in flight.
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_last_r <= issue_last;
      rd_fill_r <= wp_r - rp_inc;
    end
    out_byte_r <= out_byte_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_fill_r <= out_fill_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_has_data      = out_data_r;
  assign out_last          = out_last_r;
  assign out_overflow_flag = out_ovf_r;
  assign out_fill_level    = out_fill_r;

  `PRB_ASSERT_IMP(a_data_no_ovf, clk, rst_n, out_valid && out_has_data, !out_overflow_flag,
    "packet beat shows overflow flag")
  `PRB_ASSERT_IMP(a_read_in_send, clk, rst_n, rd_vld_r, (state_r == ST_SEND) && busy_r,
    "read data pending outside packet drain")
  `PRB_ASSERT_NXT(a_wp_hold, clk, rst_n, state_r == ST_SEND, $stable(wp_r),
    "write pointer moved during packet drain")

endmodule

`default_nettype wire

// ===== src/prb_ram.sv =====
// Simple dual-port byte store: one write port, one read port, registered read.
// Depends on nothing; sized by its parameters.
`default_nettype none

module prb_ram #(
  parameter int AW = 15,
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read so a stalled byte is not lost.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
